// ===== rtl/core/led_pkg.sv =====
`default_nettype none
package led_pkg;

  // Longest reference and longest query, in bytes.
  localparam int MAX_LEN = 64;
  // Width of lengths and of column values (0 .. MAX_LEN).
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  // Width of an index into the row of cells.
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  // Width and largest value of the reported distance.
  localparam int DIST_OUT_W = 7;
  localparam int DIST_OUT_MAX = (1 << DIST_OUT_W) - 1;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_REF    = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_FINISH = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [DIST_OUT_W-1:0] distance;
    logic                  overflow;
  } out_item_t;

  // One query byte travelling along the row, with the two values of the
  // column to the left: after this byte (left_new) and before it (left_old).
  typedef struct packed {
    logic             valid;
    logic [7:0]       q;
    logic [LEN_W-1:0] left_new;
    logic [LEN_W-1:0] left_old;
  } wave_t;

  // Commands broadcast to every cell.
  typedef struct packed {
    logic       clear;
    logic       reinit;
    logic [7:0] wr_data;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/led_cell.sv =====
`default_nettype none
module led_cell
  import led_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [LEN_W-1:0] init_val,
  input  wire ctrl_t            ctrl,
  input  wire logic             wr_en,
  input  wire wave_t            wave_in,
  output wave_t                 wave_out,
  output logic [LEN_W-1:0]      col_val
);

  logic [7:0]       ref_r;
  logic             ref_vld_r;
  logic [LEN_W-1:0] v_r;
  wave_t            wave_r;

  logic [LEN_W:0]   cost_up;
  logic [LEN_W:0]   cost_left;
  logic [LEN_W:0]   cost_diag;
  logic [LEN_W:0]   best_a;
  logic [LEN_W:0]   best;
  logic [LEN_W-1:0] new_val;

  // One step of the edit distance recurrence for this column.
  always_comb begin
    cost_up   = {1'b0, v_r} + 1'b1;
    cost_left = {1'b0, wave_in.left_new} + 1'b1;
    cost_diag = {1'b0, wave_in.left_old} + ((ref_r == wave_in.q) ? 1'b0 : 1'b1);
    best_a    = (cost_up < cost_left) ? cost_up : cost_left;
    best      = (best_a < cost_diag) ? best_a : cost_diag;
    new_val   = best[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      ref_vld_r    <= 1'b0;
      v_r          <= init_val;
      wave_r.valid <= 1'b0;
    end else if (ctrl.reinit) begin
      v_r          <= init_val;
      wave_r.valid <= 1'b0;
    end else begin
      if (wr_en) begin
        ref_vld_r <= 1'b1;
      end
      if (wave_in.valid && ref_vld_r) begin
        v_r <= new_val;
      end
      wave_r.valid <= wave_in.valid;
    end
    // The reference byte and the data half of the wave need no reset.
    if (wr_en) begin
      ref_r <= ctrl.wr_data;
    end
    wave_r.q        <= wave_in.q;
    wave_r.left_new <= ref_vld_r ? new_val : v_r;
    wave_r.left_old <= v_r;
  end

  assign wave_out = wave_r;
  assign col_val  = v_r;

endmodule
`default_nettype wire

// ===== rtl/core/levenshtein_edit_distance_unit.sv =====
`default_nettype none
// Flow: a query byte enters a head register when taken and sweeps the row of
// cells, one cell per cycle. Throughput: one item per cycle for reference and
// query bytes; a finish item waits until the drain counter set by the last
// query byte has run out and the output register can take the result, which
// appears in the cycle after the finish is taken. Synchronous active-low reset
// empties the reference and the query and loads column i with i.
module levenshtein_edit_distance_unit
  import led_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  // The row is a chain of cells. Cell j keeps reference byte j and the
  // column value dp_row[j+1]. Column zero is never stored: after k query
  // bytes it always equals k, so the query length counter stands in for it.
  // A query byte enters a head register and then walks one cell per cycle.
  // Each cell hands its right neighbor the byte together with its own value
  // before and after the byte, which is what the recurrence needs there.
  // Successive query bytes follow each other along the row, forming a diagonal
  // wavefront.

  logic [LEN_W-1:0] ref_len_r, ref_len_nxt;
  logic [LEN_W-1:0] qlen_r, qlen_nxt;
  logic             ovf_r, ovf_nxt;
  logic [LEN_W-1:0] drain_r, drain_nxt;
  wave_t            head_r, head_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  ctrl_t            ctrl;
  logic             ref_wr;
  logic             accept;
  logic             finish_block;

  wave_t            wave [MAX_LEN+1];
  logic [LEN_W-1:0] col_val [MAX_LEN];

  logic [IDX_W-1:0]          sel_idx;
  logic [LEN_W-1:0]          sel_val;
  logic [LEN_W+DIST_OUT_W-1:0] sel_ext;

  // A finish item must see every column settled and must find the output
  // register free (or being emptied in this cycle). Other items never wait.
  assign finish_block = (drain_r != '0) || (out_valid_r && out_stall);
  assign in_stall     = (in_item.mode == MODE_FINISH) && finish_block;
  assign accept       = in_valid && !in_stall;

  // The result is dp_row[ref_length]; for an empty reference that is the
  // query length.
  always_comb begin
    sel_idx = IDX_W'(LEN_W'(ref_len_r - 1'b1));
    sel_val = (ref_len_r == '0) ? qlen_r : col_val[sel_idx];
    sel_ext = {{DIST_OUT_W{1'b0}}, sel_val};
  end

  always_comb begin
    ref_len_nxt   = ref_len_r;
    qlen_nxt      = qlen_r;
    ovf_nxt       = ovf_r;
    drain_nxt     = (drain_r != '0) ? LEN_W'(drain_r - 1'b1) : drain_r;
    head_nxt      = head_r;
    head_nxt.valid = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    ctrl.clear    = 1'b0;
    ctrl.reinit   = 1'b0;
    ctrl.wr_data  = in_item.char_code;
    ref_wr        = 1'b0;

    if (accept) begin
      unique case (in_item.mode)
        MODE_CLEAR: begin
          ctrl.clear  = 1'b1;
          ref_len_nxt = '0;
          qlen_nxt    = '0;
          ovf_nxt     = 1'b0;
          drain_nxt   = '0;
        end
        MODE_REF: begin
          // Reference bytes are taken only before the first query byte.
          if (qlen_r != '0 || ref_len_r == LEN_W'(MAX_LEN)) begin
            ovf_nxt = 1'b1;
          end else begin
            ref_wr      = 1'b1;
            ref_len_nxt = LEN_W'(ref_len_r + 1'b1);
          end
        end
        MODE_QUERY: begin
          if (qlen_r == LEN_W'(MAX_LEN)) begin
            ovf_nxt = 1'b1;
          end else begin
            head_nxt.valid    = 1'b1;
            head_nxt.q        = in_item.char_code;
            head_nxt.left_new = LEN_W'(qlen_r + 1'b1);
            head_nxt.left_old = qlen_r;
            qlen_nxt          = LEN_W'(qlen_r + 1'b1);
            drain_nxt         = LEN_W'(MAX_LEN);
          end
        end
        MODE_FINISH: begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.distance = (sel_ext > (LEN_W+DIST_OUT_W)'(DIST_OUT_MAX)) ?
                                  DIST_OUT_W'(DIST_OUT_MAX) : sel_ext[DIST_OUT_W-1:0];
          out_item_nxt.overflow = ovf_r;
          ctrl.reinit           = 1'b1;
          qlen_nxt              = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_len_r    <= '0;
      qlen_r       <= '0;
      ovf_r        <= 1'b0;
      drain_r      <= '0;
      head_r.valid <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      ref_len_r    <= ref_len_nxt;
      qlen_r       <= qlen_nxt;
      ovf_r        <= ovf_nxt;
      drain_r      <= drain_nxt;
      head_r.valid <= head_nxt.valid;
      out_valid_r  <= out_valid_nxt;
    end
    // The data half of the head register needs no reset.
    head_r.q        <= head_nxt.q;
    head_r.left_new <= head_nxt.left_new;
    head_r.left_old <= head_nxt.left_old;
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign wave[0] = head_r;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    led_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .init_val (LEN_W'(j + 1)),
      .ctrl     (ctrl),
      .wr_en    (ref_wr && (ref_len_r == LEN_W'(j))),
      .wave_in  (wave[j]),
      .wave_out (wave[j+1]),
      .col_val  (col_val[j])
    );
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire
